// ===== rtl/core/ima_pkg.sv =====
// ----------------------------------------------------------------------------
// ima_pkg
// Shared constants and helper functions for the IMU axis moving average core.
// ----------------------------------------------------------------------------
package ima_pkg;

   // Width of one axis sample and of one axis result.
   localparam int SAMPLE_W = 16;

   // Number of axes carried in one item.
   localparam int NUM_AXES = 3;

   // Default depth of the averaging ring and length of a calibration run.
   localparam int DEF_AVG_DEPTH   = 8;
   localparam int DEF_CAL_SAMPLES = 32;

   // Control register port.
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 1;

   localparam logic [CSR_IDX_W-1:0] CSR_USE_OFFSET = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_NEGATE_YZ  = 2'd1;

   // Floor of log2 for a positive constant.
   function automatic int floor_log2(input int value);
      return $clog2(value + 1) - 1;
   endfunction

   // Width of a ring sum shifted right by floor(log2(depth)).
   function automatic int avg_width(input int depth);
      return SAMPLE_W + $clog2(depth) - floor_log2(depth);
   endfunction

endpackage

// ===== rtl/core/ima_avg_ring.sv =====
// ----------------------------------------------------------------------------
// ima_avg_ring
// One axis of the moving average: a ring of recent samples with a running
// sum, and a registered average of the ring after each push.
// ----------------------------------------------------------------------------
module ima_avg_ring #(
   parameter int DEPTH = ima_pkg::DEF_AVG_DEPTH
) (
   input  logic                                          clock,
   input  logic                                          reset,
   input  logic                                          push,
   input  logic signed [ima_pkg::SAMPLE_W-1:0]           sample,
   output logic signed [ima_pkg::avg_width(DEPTH)-1:0]   avg
);

   localparam int SLOT_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int SUM_W  = ima_pkg::SAMPLE_W + $clog2(DEPTH);
   localparam int SHIFT  = ima_pkg::floor_log2(DEPTH);
   localparam int AVG_W  = ima_pkg::avg_width(DEPTH);

   logic signed [ima_pkg::SAMPLE_W-1:0] ring_ff [DEPTH];
   logic        [SLOT_W-1:0]            slot_ff;
   logic        [SLOT_W-1:0]            slot_in;
   logic signed [SUM_W-1:0]             sum_ff;
   logic signed [SUM_W-1:0]             sum_in;
   logic signed [AVG_W-1:0]             avg_ff;
   logic signed [SUM_W:0]               sum_wide;

   // The running sum drops the oldest entry and takes in the new sample.
   always_comb begin
      sum_wide = (SUM_W+1)'(sum_ff) - (SUM_W+1)'(ring_ff[slot_ff]) + (SUM_W+1)'(sample);
      sum_in   = sum_wide[SUM_W-1:0];
      slot_in  = (slot_ff == SLOT_W'(DEPTH - 1)) ? '0 : slot_ff + SLOT_W'(1);
   end

   // Ring, write slot and sum registers; the average follows each push.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DEPTH; i++) begin
            ring_ff[i] <= '0;
         end
         slot_ff <= '0;
         sum_ff  <= '0;
      end else if (push) begin
         ring_ff[slot_ff] <= sample;
         slot_ff          <= slot_in;
         sum_ff           <= sum_in;
      end
   end

   // Average register; only meaningful once a push has taken place.
   always_ff @(posedge clock) begin
      if (push) begin
         avg_ff <= AVG_W'(sum_in >>> SHIFT);
      end
   end

   assign avg = avg_ff;

endmodule

// ===== rtl/core/imu_axis_moving_average_with_bias_cal_core.sv =====
// ----------------------------------------------------------------------------
// imu_axis_moving_average_with_bias_cal_core
// Three-axis moving average with optional bias correction, Y/Z negation and
// bias calibration over a run of marked items.
// ----------------------------------------------------------------------------
// The core accepts one item per clock cycle while req_stall is low. After
// an item is accepted, the first register it reaches holds the ring
// averages, the second the corrected result. Each axis keeps a running sum
// of its last AVG_DEPTH samples, so the average costs one add and one
// subtract no matter how deep the ring is. With use_offset set the stored
// bias is subtracted, with negate_yz set Y and Z change sign, and any result
// that does not fit 16 bits is wrapped and flagged. Items marked calibrate
// add their results into per-axis sums; the item that completes a run of
// CAL_SAMPLES loads the new bias, which then applies from the next item on.
// A stalled result holds the pipeline; no input is taken while both stages
// are full and the output is stalled.
module imu_axis_moving_average_with_bias_cal_core #(
   parameter int AVG_DEPTH   = ima_pkg::DEF_AVG_DEPTH,
   parameter int CAL_SAMPLES = ima_pkg::DEF_CAL_SAMPLES
) (
   input  logic                                  clock,
   input  logic                                  reset,

   input  logic                                  csr_we,
   input  logic [ima_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [ima_pkg::CSR_DATA_W-1:0]        csr_wdata,

   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic signed [ima_pkg::SAMPLE_W-1:0]   req_sample_x,
   input  logic signed [ima_pkg::SAMPLE_W-1:0]   req_sample_y,
   input  logic signed [ima_pkg::SAMPLE_W-1:0]   req_sample_z,
   input  logic                                  req_sample_valid,
   input  logic                                  req_calibrate,

   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic signed [ima_pkg::SAMPLE_W-1:0]   rsp_out_x,
   output logic signed [ima_pkg::SAMPLE_W-1:0]   rsp_out_y,
   output logic signed [ima_pkg::SAMPLE_W-1:0]   rsp_out_z,
   output logic                                  rsp_overflow,
   output logic                                  rsp_calibration_done
);

   localparam int NAX    = ima_pkg::NUM_AXES;
   localparam int SW     = ima_pkg::SAMPLE_W;
   localparam int AVG_W  = ima_pkg::avg_width(AVG_DEPTH);
   localparam int CORR_W = AVG_W + 2;
   localparam int CNT_W  = $clog2(CAL_SAMPLES);
   localparam int CSUM_W = SW + $clog2(CAL_SAMPLES);
   localparam int CSHIFT = ima_pkg::floor_log2(CAL_SAMPLES);

   // Control registers.
   logic use_offset_ff;
   logic negate_yz_ff;

   // Pipeline control.
   logic req_accept;
   logic out_take;
   logic mid_adv;
   logic mid_valid_ff;
   logic mid_valid_in;
   logic mid_cal_ff;
   logic rsp_valid_ff;
   logic rsp_valid_in;

   // Datapath.
   logic signed [SW-1:0]     sample_sel [NAX];
   logic signed [AVG_W-1:0]  avg        [NAX];
   logic signed [SW-1:0]     res        [NAX];
   logic signed [CSUM_W-1:0] cal_sum_in [NAX];
   logic signed [SW-1:0]     bias_in    [NAX];
   logic                     ovf_in;
   logic                     done_in;

   // Calibration state.
   logic signed [CSUM_W-1:0] cal_sum_ff [NAX];
   logic signed [SW-1:0]     bias_ff    [NAX];
   logic        [CNT_W-1:0]  cal_count_ff;

   // Result registers.
   logic signed [SW-1:0] out_ff [NAX];
   logic                 ovf_ff;
   logic                 done_ff;

   // Control register writes; indexes beyond the list are ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         use_offset_ff <= 1'b0;
         negate_yz_ff  <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_index)
            ima_pkg::CSR_USE_OFFSET: use_offset_ff <= csr_wdata[0];
            ima_pkg::CSR_NEGATE_YZ:  negate_yz_ff  <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // Handshake: the average stage moves on whenever the result register is
   // free or being taken.
   assign out_take   = !rsp_valid_ff || !rsp_stall;
   assign mid_adv    = mid_valid_ff && out_take;
   assign req_stall  = mid_valid_ff && !out_take;
   assign req_accept = req_valid && !req_stall;

   always_comb begin
      mid_valid_in = req_accept ? 1'b1 : (mid_adv ? 1'b0 : mid_valid_ff);
      rsp_valid_in = mid_adv ? 1'b1 : (rsp_stall ? rsp_valid_ff : 1'b0);
   end

   // A timed-out sample pushes zeros into every ring.
   assign sample_sel[0] = req_sample_valid ? req_sample_x : '0;
   assign sample_sel[1] = req_sample_valid ? req_sample_y : '0;
   assign sample_sel[2] = req_sample_valid ? req_sample_z : '0;

   // One averaging ring per axis.
   for (genvar g = 0; g < NAX; g++) begin : g_axis
      ima_avg_ring #(
         .DEPTH (AVG_DEPTH)
      ) u_ring (
         .clock  (clock),
         .reset  (reset),
         .push   (req_accept),
         .sample (sample_sel[g]),
         .avg    (avg[g])
      );
   end

   // Bias correction, negation, wrap detection and calibration sums.
   always_comb begin
      logic signed [CORR_W-1:0] corr;
      logic signed [CSUM_W-1:0] shifted;
      ovf_in = 1'b0;
      for (int a = 0; a < NAX; a++) begin
         corr = CORR_W'(avg[a]);
         if (use_offset_ff) begin
            corr = corr - CORR_W'(bias_ff[a]);
         end
         if (negate_yz_ff && (a != 0)) begin
            corr = -corr;
         end
         res[a] = corr[SW-1:0];
         if (corr != CORR_W'(res[a])) begin
            ovf_in = 1'b1;
         end
         cal_sum_in[a] = cal_sum_ff[a] + CSUM_W'(res[a]);
         shifted       = cal_sum_in[a] >>> CSHIFT;
         bias_in[a]    = shifted[SW-1:0];
      end
      done_in = mid_cal_ff && (cal_count_ff == CNT_W'(CAL_SAMPLES - 1));
   end

   // Pipeline valid flags and the calibration state.
   always_ff @(posedge clock) begin
      if (reset) begin
         mid_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         cal_count_ff <= '0;
         for (int a = 0; a < NAX; a++) begin
            cal_sum_ff[a] <= '0;
            bias_ff[a]    <= '0;
         end
      end else begin
         mid_valid_ff <= mid_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (mid_adv && mid_cal_ff) begin
            if (done_in) begin
               cal_count_ff <= '0;
               for (int a = 0; a < NAX; a++) begin
                  cal_sum_ff[a] <= '0;
                  bias_ff[a]    <= bias_in[a];
               end
            end else begin
               cal_count_ff <= cal_count_ff + CNT_W'(1);
               for (int a = 0; a < NAX; a++) begin
                  cal_sum_ff[a] <= cal_sum_in[a];
               end
            end
         end
      end
   end

   // Payload registers of both stages.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         mid_cal_ff <= req_calibrate;
      end
      if (mid_adv) begin
         for (int a = 0; a < NAX; a++) begin
            out_ff[a] <= res[a];
         end
         ovf_ff  <= ovf_in;
         done_ff <= done_in;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_out_x            = out_ff[0];
   assign rsp_out_y            = out_ff[1];
   assign rsp_out_z            = out_ff[2];
   assign rsp_overflow         = ovf_ff;
   assign rsp_calibration_done = done_ff;

   // A stalled result must keep the average stage from moving on.
   a_stall_holds_mid: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |-> !mid_adv)
      else $error("average stage advanced into a stalled result");

   // The calibration count never reaches the run length.
   a_cal_count_range: assert property (@(posedge clock) disable iff (reset)
      cal_count_ff <= CNT_W'(CAL_SAMPLES - 1))
      else $error("calibration count out of range");

   // A completed calibration leaves the count and the X axis sum cleared.
   a_cal_restart: assert property (@(posedge clock) disable iff (reset)
      (mid_adv && done_in) |=> (cal_count_ff == '0) && (cal_sum_ff[0] == '0))
      else $error("calibration state not cleared after completion");

   // Every item that leaves the average stage shows up as a valid result.
   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      mid_adv |=> rsp_valid_ff)
      else $error("result lost after average stage");

endmodule
